### rtl/wsfe_pkg.sv
`timescale 1ns / 1ps
package wsfe_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int FIFO_DEPTH_DEF  = 4;
  localparam int LEN_W           = 32;
  localparam int POS_W           = 4;

  localparam logic [31:0] MASK_KEY_RESET = 32'h1122_3344;
  localparam logic [7:0]  HDR_FIN_BIN    = 8'h82;
  localparam logic [7:0]  MASK_BIT       = 8'h80;
  localparam logic [7:0]  LEN_CODE_16    = 8'hFE;
  localparam logic [7:0]  LEN_CODE_64    = 8'hFF;
  localparam logic [LEN_W-1:0] LEN_SHORT_LIM = 32'd126;
  localparam logic [LEN_W-1:0] LEN_MID_LIM   = 32'd65536;

  // header byte counts (0x82 + length form + four key bytes)
  localparam logic [POS_W-1:0] NHDR_SHORT = 4'd6;
  localparam logic [POS_W-1:0] NHDR_MID   = 4'd8;
  localparam logic [POS_W-1:0] NHDR_LONG  = 4'd14;
  localparam logic [POS_W-1:0] KEY_BASE_SHORT = 4'd2;
  localparam logic [POS_W-1:0] KEY_BASE_MID   = 4'd4;
  localparam logic [POS_W-1:0] KEY_BASE_LONG  = 4'd10;

  typedef enum logic [1:0] {
    FORM_SHORT = 2'd0,
    FORM_MID   = 2'd1,
    FORM_LONG  = 2'd2
  } len_form_e;

  typedef struct packed {
    logic        start_frame;
    logic [31:0] frame_length;
    logic [7:0]  payload_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_header;
    logic       end_of_frame;
    logic       last_of_run;
  } out_beat_t;

  // one queued job: optional header, optional masked payload byte
  typedef struct packed {
    logic             has_hdr;
    len_form_e        form;
    logic [LEN_W-1:0] frame_len;
    logic [31:0]      key;
    logic             has_pay;
    logic [7:0]       pay_byte;
    logic             pay_eof;
  } job_t;

  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

### rtl/websocket_frame_encoder_core.sv
`timescale 1ns / 1ps
// Client-side WebSocket frame encoder.
// Input channel (in_valid_i/in_ready_o/in_beat_i): one payload byte per beat.
// A beat with start_frame set opens a frame of frame_length bytes; the block
// first sends 0x82, the masked length (1, 3 or 9 bytes) and the four mask-key
// bytes, then any masked payload byte. Bytes with no frame open yield nothing.
// Output channel (out_valid_o/out_ready_i/out_beat_o): one framed byte per
// beat, flagged as header, end of frame, and last byte of its input beat.
// mask_key_we_i/mask_key_i write the key; write only while the block is idle.
// Throughput: one output byte per cycle while out_ready_i is high and the
// queue holds jobs, set by the single output register; a payload beat yields
// one byte, a start beat 6, 8 or 14 header bytes plus any payload byte. A
// 4-entry job queue sits between the classifier and the byte sequencer.
// Reset clears the queue and output register, closes any open frame and
// restores the key to 0x11223344.
// When out_ready_i is low the output holds; the queue keeps taking input
// beats until it fills, then in_ready_o drops.
module websocket_frame_encoder_core #(
  parameter int LENGTH_BITS = wsfe_pkg::LENGTH_BITS_DEF,
  parameter int FIFO_DEPTH  = wsfe_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                mask_key_we_i,
  input  logic [31:0]         mask_key_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wsfe_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wsfe_pkg::out_beat_t out_beat_o
);

  logic           q_full, q_push, q_empty, q_pop;
  wsfe_pkg::job_t push_job, head_job;

  wsfe_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mask_key_we_i (mask_key_we_i),
    .mask_key_i    (mask_key_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_beat_i     (in_beat_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_job_o       (push_job)
  );

  wsfe_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_job_o (head_job)
  );

  wsfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_job_i     (head_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

### rtl/wsfe_front.sv
`timescale 1ns / 1ps
module wsfe_front #(
  parameter int LENGTH_BITS = wsfe_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mask_key_we_i,
  input  logic [31:0]       mask_key_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wsfe_pkg::in_beat_t in_beat_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output wsfe_pkg::job_t    q_job_o
);

  localparam int CNT_W = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

  logic [31:0]      mask_key_q;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [1:0]       phase_q, phase_d;
  logic [CNT_W-1:0] len;
  logic             len_zero;
  logic             accept;
  logic [1:0]       pay_phase;
  wsfe_pkg::job_t   job;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign len        = in_beat_i.frame_length[CNT_W-1:0];
  assign len_zero   = (len == '0);

  always_comb begin
    job           = '0;
    job.key       = mask_key_q;
    job.frame_len = wsfe_pkg::LEN_W'(len);
    if (job.frame_len < wsfe_pkg::LEN_SHORT_LIM) begin
      job.form = wsfe_pkg::FORM_SHORT;
    end else if (job.frame_len < wsfe_pkg::LEN_MID_LIM) begin
      job.form = wsfe_pkg::FORM_MID;
    end else begin
      job.form = wsfe_pkg::FORM_LONG;
    end
    rem_d   = rem_q;
    phase_d = phase_q;
    if (in_beat_i.start_frame) begin
      job.has_hdr = 1'b1;
      job.has_pay = !len_zero;
      job.pay_eof = (len == CNT_W'(1));
      pay_phase   = 2'd0;
      rem_d       = len_zero ? len : len - CNT_W'(1);
      phase_d     = len_zero ? 2'd0 : 2'd1;
    end else begin
      job.has_pay = (rem_q != '0);
      job.pay_eof = (rem_q == CNT_W'(1));
      pay_phase   = phase_q;
      if (rem_q != '0) begin
        rem_d   = rem_q - CNT_W'(1);
        phase_d = phase_q + 2'd1;
      end
    end
    job.pay_byte = in_beat_i.payload_byte ^ wsfe_pkg::key_byte(mask_key_q, pay_phase);
  end

  assign q_push_o = accept && (job.has_hdr || job.has_pay);
  assign q_job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_key_q <= wsfe_pkg::MASK_KEY_RESET;
      rem_q      <= '0;
      phase_q    <= 2'd0;
    end else begin
      if (mask_key_we_i) begin
        mask_key_q <= mask_key_i;
      end
      if (accept) begin
        rem_q   <= rem_d;
        phase_q <= phase_d;
      end
    end
  end

endmodule

### rtl/wsfe_fifo.sv
`timescale 1ns / 1ps
module wsfe_fifo #(
  parameter int DEPTH = wsfe_pkg::FIFO_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wsfe_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output wsfe_pkg::job_t head_job_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wsfe_pkg::job_t   slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign head_job_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/wsfe_back.sv
`timescale 1ns / 1ps
module wsfe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  wsfe_pkg::job_t     q_job_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wsfe_pkg::out_beat_t out_beat_o
);

  logic [wsfe_pkg::POS_W-1:0] pos_q;
  logic [wsfe_pkg::POS_W-1:0] nhdr, key_base, total, key_off;
  logic                       out_valid_q;
  wsfe_pkg::out_beat_t        out_beat_q;
  wsfe_pkg::out_beat_t        beat;
  logic [7:0]                 hdr_byte;
  logic [wsfe_pkg::LEN_W-1:0] len;
  logic                       load;

  assign len = q_job_i.frame_len;

  always_comb begin
    case (q_job_i.form)
      wsfe_pkg::FORM_SHORT: begin
        nhdr     = wsfe_pkg::NHDR_SHORT;
        key_base = wsfe_pkg::KEY_BASE_SHORT;
      end
      wsfe_pkg::FORM_MID: begin
        nhdr     = wsfe_pkg::NHDR_MID;
        key_base = wsfe_pkg::KEY_BASE_MID;
      end
      default: begin
        nhdr     = wsfe_pkg::NHDR_LONG;
        key_base = wsfe_pkg::KEY_BASE_LONG;
      end
    endcase
    if (!q_job_i.has_hdr) begin
      nhdr = '0;
    end
    total   = nhdr + wsfe_pkg::POS_W'(q_job_i.has_pay);
    key_off = pos_q - key_base;

    hdr_byte = 8'h00;
    if (pos_q == '0) begin
      hdr_byte = wsfe_pkg::HDR_FIN_BIN;
    end else if (pos_q >= key_base) begin
      hdr_byte = wsfe_pkg::key_byte(q_job_i.key, key_off[1:0]);
    end else begin
      case (q_job_i.form)
        wsfe_pkg::FORM_SHORT: hdr_byte = wsfe_pkg::MASK_BIT | {1'b0, len[6:0]};
        wsfe_pkg::FORM_MID: begin
          case (pos_q)
            4'd1:    hdr_byte = wsfe_pkg::LEN_CODE_16;
            4'd2:    hdr_byte = len[15:8];
            default: hdr_byte = len[7:0];
          endcase
        end
        default: begin
          case (pos_q)
            4'd1:    hdr_byte = wsfe_pkg::LEN_CODE_64;
            4'd6:    hdr_byte = len[31:24];
            4'd7:    hdr_byte = len[23:16];
            4'd8:    hdr_byte = len[15:8];
            4'd9:    hdr_byte = len[7:0];
            default: hdr_byte = 8'h00;
          endcase
        end
      endcase
    end

    beat.last_of_run = (pos_q == total - wsfe_pkg::POS_W'(1));
    if (pos_q < nhdr) begin
      beat.out_byte     = hdr_byte;
      beat.is_header    = 1'b1;
      beat.end_of_frame = !q_job_i.has_pay && (pos_q == nhdr - wsfe_pkg::POS_W'(1));
    end else begin
      beat.out_byte     = q_job_i.pay_byte;
      beat.is_header    = 1'b0;
      beat.end_of_frame = q_job_i.pay_eof;
    end
  end

  assign load        = !q_empty_i && (!out_valid_q || out_ready_i);
  assign q_pop_o     = load && beat.last_of_run;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_beat_q <= beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        pos_q       <= beat.last_of_run ? '0 : pos_q + wsfe_pkg::POS_W'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### tb/wsfe_frame_checker.sv
`timescale 1ns / 1ps
module wsfe_frame_checker
  import wsfe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      mask_key_we_i,
  input  logic [31:0] mask_key_i,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_beat_t  in_beat_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_beat_t out_beat_i,
  output int        errors_o,
  output int        pending_o,
  output int        checked_o
);

  localparam logic [7:0] FIN_BINARY = 8'h82;
  localparam logic [7:0] MASKED     = 8'h80;
  localparam logic [7:0] LEN16_CODE = 8'd126;
  localparam logic [7:0] LEN64_CODE = 8'd127;

  logic [31:0] key_q;
  logic [31:0] bytes_left;
  logic [1:0]  key_phase;
  out_beat_t   beat_bytes[$];
  out_beat_t   frame_bytes_due[$];
  int          err_cnt = 0;
  int          byte_cnt = 0;

  assign errors_o  = err_cnt;
  assign checked_o = byte_cnt;

  function automatic logic [7:0] key_sel(input logic [31:0] k, input logic [1:0] p);
    int base;
    base = 8 * (3 - int'(p));
    return k[base +: 8];
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic hdr, input logic eof);
    beat_bytes.push_back({b, hdr, eof, 1'b0});
  endtask

  task automatic predict_beat(input in_beat_t b);
    logic [31:0] n;
    int i;
    beat_bytes.delete();
    if (b.start_frame) begin
      n = b.frame_length;
      add_byte(FIN_BINARY, 1'b1, 1'b0);
      if (n < 32'd126) begin
        add_byte(MASKED | n[7:0], 1'b1, 1'b0);
      end else if (n < 32'd65536) begin
        add_byte(MASKED | LEN16_CODE, 1'b1, 1'b0);
        add_byte(n[15:8], 1'b1, 1'b0);
        add_byte(n[7:0], 1'b1, 1'b0);
      end else begin
        add_byte(MASKED | LEN64_CODE, 1'b1, 1'b0);
        repeat (4) add_byte(8'h00, 1'b1, 1'b0);
        add_byte(n[31:24], 1'b1, 1'b0);
        add_byte(n[23:16], 1'b1, 1'b0);
        add_byte(n[15:8], 1'b1, 1'b0);
        add_byte(n[7:0], 1'b1, 1'b0);
      end
      for (i = 0; i < 4; i++) begin
        add_byte(key_sel(key_q, i[1:0]), 1'b1, (n == 0) && (i == 3));
      end
      bytes_left = n;
      key_phase  = 2'd0;
    end
    if (bytes_left != 0) begin
      bytes_left = bytes_left - 1;
      add_byte(b.payload_byte ^ key_sel(key_q, key_phase), 1'b0, bytes_left == 0);
      key_phase = key_phase + 2'd1;
    end
    for (i = 0; i < beat_bytes.size(); i++) begin
      frame_bytes_due.push_back({beat_bytes[i][10:1], i == beat_bytes.size() - 1});
    end
  endtask

  task automatic check_byte(input out_beat_t got);
    out_beat_t want;
    byte_cnt++;
    if (frame_bytes_due.size() == 0) begin
      err_cnt++;
      $display("%0t: output byte with nothing due: expected none, got byte %h hdr %b eof %b last %b",
               $time, got.out_byte, got.is_header, got.end_of_frame, got.last_of_run);
    end else begin
      want = frame_bytes_due.pop_front();
      if (got.out_byte !== want.out_byte || got.is_header !== want.is_header ||
          got.end_of_frame !== want.end_of_frame || got.last_of_run !== want.last_of_run) begin
        err_cnt++;
        $display("%0t: mismatch: expected byte %h hdr %b eof %b last %b, got byte %h hdr %b eof %b last %b",
                 $time, want.out_byte, want.is_header, want.end_of_frame, want.last_of_run,
                 got.out_byte, got.is_header, got.end_of_frame, got.last_of_run);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      = MASK_KEY_RESET;
      bytes_left = '0;
      key_phase  = '0;
      frame_bytes_due.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_byte(out_beat_i);
      if (in_valid_i && in_ready_i) predict_beat(in_beat_i);
      if (mask_key_we_i) key_q = mask_key_i;
      pending_o <= frame_bytes_due.size();
    end
  end

endmodule

### tb/websocket_frame_encoder_core_test.sv
`timescale 1ns / 1ps
module websocket_frame_encoder_core_test;
  import wsfe_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 27;
  localparam int PHASE_BEATS  = 46;
  localparam int SETTLE       = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        mask_key_we = 1'b0;
  logic [31:0] mask_key = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_beat_t    in_beat = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_beat;

  logic calm = 1'b0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   cycles = 0;
  int   beats_sent = 0;
  int   strays = 0;
  int   key_writes = 0;
  int   errors, pending, checked;

  logic [31:0] phase_keys[6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001,
                                 32'h0, 32'h7FFF_FFFE, 32'h0};

  websocket_frame_encoder_core u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .mask_key_we_i(mask_key_we),
    .mask_key_i   (mask_key),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_beat_i    (in_beat),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_beat_o   (out_beat)
  );

  wsfe_frame_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .mask_key_we_i(mask_key_we),
    .mask_key_i   (mask_key),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_beat_i    (in_beat),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_beat_i   (out_beat),
    .errors_o     (errors),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("websocket_frame_encoder_core_test: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_beat(input logic start, input logic [31:0] len, input logic [7:0] pb);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{start_frame: start, frame_length: len, payload_byte: pb};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_stray();
    send_beat(1'b0, $urandom, 8'($urandom));
    strays++;
  endtask

  task automatic set_key(input logic [31:0] k);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    mask_key_we <= 1'b1;
    mask_key    <= k;
    @(posedge clk);
    mask_key_we <= 1'b0;
    key_writes++;
  endtask

  task automatic random_frame();
    int unsigned kind;
    int unsigned len;
    int unsigned cnt;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(3, 1)) send_stray();
    end else if (kind < 18) begin
      send_beat(1'b1, 32'd0, 8'($urandom));
    end else if (kind < 70) begin
      len = $urandom_range(12, 1);
      send_beat(1'b1, len, 8'($urandom));
      repeat (len - 1) send_beat(1'b0, $urandom, 8'($urandom));
    end else if (kind < 72) begin
      len = $urandom_range(130, 126);
      send_beat(1'b1, len, 8'($urandom));
      repeat (len - 1) send_beat(1'b0, $urandom, 8'($urandom));
    end else if (kind < 86) begin
      // abandoned frame: next start cuts it short
      case ($urandom_range(3))
        0:       len = $urandom;
        1:       len = $urandom_range(65535, 126);
        2:       len = 32'h1_0000 + $urandom_range(1000);
        default: len = $urandom_range(12, 2);
      endcase
      if (len < 2) len = 2;
      cnt = (len > 6) ? $urandom_range(5) : $urandom_range(len - 2);
      send_beat(1'b1, len, 8'($urandom));
      repeat (cnt) send_beat(1'b0, $urandom, 8'($urandom));
    end else begin
      len = $urandom_range(6, 1);
      send_beat(1'b1, len, 8'($urandom));
      repeat (len - 1) send_beat(1'b0, $urandom, 8'($urandom));
      repeat ($urandom_range(3, 1)) send_stray();
    end
  endtask

  initial begin
    int   target;
    int   p;
    logic hold_done;
    hold_done = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats, reset key
    send_beat(1'b0, 32'd0, 8'h00);
    send_beat(1'b1, 32'd0, 8'hFF);
    send_beat(1'b1, 32'd1, 8'h00);
    send_beat(1'b0, 32'hFFFF_FFFF, 8'hFF);
    send_beat(1'b1, 32'd5, 8'hFF);
    send_beat(1'b0, 32'd0, 8'h00);
    send_beat(1'b0, 32'd0, 8'hFF);
    send_beat(1'b0, 32'd0, 8'h5A);
    send_beat(1'b0, 32'd0, 8'hA5);
    send_beat(1'b1, 32'd125, 8'h00);
    send_beat(1'b0, 32'd0, 8'h3C);
    send_beat(1'b1, 32'd126, 8'h81);
    send_beat(1'b1, 32'd65535, 8'h7E);
    send_beat(1'b1, 32'd65536, 8'h01);
    send_beat(1'b1, 32'hFFFF_FFFF, 8'hFF);
    send_beat(1'b0, 32'd0, 8'h80);
    send_beat(1'b1, 32'd0, 8'h55);
    send_beat(1'b0, 32'd7, 8'h11);
    send_beat(1'b1, 32'd2, 8'hC3);
    send_beat(1'b0, 32'd0, 8'h96);
    send_beat(1'b1, 32'hAAAA_5555, 8'hAA);
    send_beat(1'b1, 32'h5555_AAAA, 8'h55);
    strays += 3;

    phase_keys[3] = $urandom;
    phase_keys[5] = $urandom;
    for (p = 0; p < 6; p++) begin
      // key changes while the last frame of the previous phase is still open
      set_key(phase_keys[p]);
      calm <= (p == 2);
      repeat (3) send_beat(1'b0, $urandom, 8'($urandom));
      target = beats_sent - strays + PHASE_BEATS;
      while (beats_sent - strays < target) begin
        if (p == 3 && !hold_done &&
            beats_sent - strays >= target - PHASE_BEATS / 2) begin
          hold_req <= hold_req + 1;
          hold_done = 1'b1;
        end
        random_frame();
      end
      send_beat(1'b1, 32'd10, 8'($urandom));
      repeat (3) send_beat(1'b0, $urandom, 8'($urandom));
    end

    in_valid <= 1'b0;
    calm <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d input beats (%0d extra non-start beats), %0d output bytes checked",
             beats_sent, strays, checked);
    $display("reset key plus %0d key writes, one receiver hold-off of %0d cycles",
             key_writes, HOLD_CYCLES);
    if (errors == 0) begin
      $display("websocket_frame_encoder_core_test: done, clean");
    end else begin
      $display("websocket_frame_encoder_core_test: done, errors");
    end
    $finish;
  end

endmodule
